[rtl/core/plme_pkg.sv]
package plme_pkg;

	localparam logic [1:0] ACT_CLEAR    = 2'd0;
	localparam logic [1:0] ACT_APPEND_A = 2'd1;
	localparam logic [1:0] ACT_APPEND_B = 2'd2;
	localparam logic [1:0] ACT_RUN      = 2'd3;

	localparam logic [1:0] OP_AND = 2'd0;
	localparam logic [1:0] OP_OR  = 2'd1;
	localparam logic [1:0] OP_NOT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} plme_state_t;

	typedef struct packed {
		logic vld;
		logic present;
		logic last;
	} plme_push_t;

endpackage

[rtl/core/plme_if.sv]
interface plme_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  op;
	logic [15:0] doc_id;

	modport source (output valid, output action, output op, output doc_id, input ready);
	modport sink   (input valid, input action, input op, input doc_id, output ready);
endinterface

interface plme_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_id;
	logic        present;
	logic        last;
	logic        overflowed;

	modport source (output valid, output result_id, output present, output last,
		output overflowed, input ready);
	modport sink   (input valid, input result_id, input present, input last,
		input overflowed, output ready);
endinterface

[rtl/core/plme_ram.sv]
module plme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/plme_merge.sv]
module plme_merge import plme_pkg::*; #(
	parameter int ID_WIDTH   = 16,
	parameter int AW         = 5,
	parameter int CW         = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op,
	input  logic [CW-1:0]       cnt_a,
	input  logic [CW-1:0]       cnt_b,
	input  logic [ID_WIDTH-1:0] rd_a,
	input  logic [ID_WIDTH-1:0] rd_b,
	input  logic                slot_free,
	output logic [AW-1:0]       raddr_a,
	output logic [AW-1:0]       raddr_b,
	output logic                busy,
	output plme_push_t          push,
	output logic [ID_WIDTH-1:0] push_id
);

	plme_state_t         state_q;
	logic [1:0]          op_q;
	logic [CW-1:0]       i_q, j_q, i_n, j_n;
	logic                pend_v_q;
	logic [ID_WIDTH-1:0] pend_id_q;

	logic                ia, jb, eq, lt, step;
	logic                done, hit, inc_i, inc_j;
	logic [ID_WIDTH-1:0] hit_id;

	assign ia   = i_q < cnt_a;
	assign jb   = j_q < cnt_b;
	assign eq   = rd_a == rd_b;
	assign lt   = rd_a < rd_b;
	assign step = (state_q == ST_MERGE) && slot_free;
	assign busy = state_q == ST_MERGE;

	always_comb begin
		done   = 1'b0;
		hit    = 1'b0;
		hit_id = rd_a;
		inc_i  = 1'b0;
		inc_j  = 1'b0;
		unique case (op_q)
			OP_AND: begin
				if (!(ia && jb)) begin
					done = 1'b1;
				end else if (eq) begin
					hit = 1'b1; inc_i = 1'b1; inc_j = 1'b1;
				end else if (lt) begin
					inc_i = 1'b1;
				end else begin
					inc_j = 1'b1;
				end
			end
			OP_OR: begin
				if (ia && jb) begin
					hit = 1'b1;
					if (eq) begin
						inc_i = 1'b1; inc_j = 1'b1;
					end else if (lt) begin
						inc_i = 1'b1;
					end else begin
						hit_id = rd_b; inc_j = 1'b1;
					end
				end else if (ia) begin
					hit = 1'b1; inc_i = 1'b1;
				end else if (jb) begin
					hit = 1'b1; hit_id = rd_b; inc_j = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			OP_NOT: begin
				if (!jb) begin
					done = 1'b1;
				end else if (ia && lt) begin
					inc_i = 1'b1;
				end else if (ia && eq) begin
					inc_i = 1'b1; inc_j = 1'b1;
				end else begin
					hit = 1'b1; hit_id = rd_b; inc_j = 1'b1;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// next pointers drive the RAM read ports so data lines up with i_q / j_q
	always_comb begin
		i_n = i_q;
		j_n = j_q;
		if (step && done) begin
			i_n = '0;
			j_n = '0;
		end else if (step) begin
			if (inc_i) i_n = i_q + CW'(1);
			if (inc_j) j_n = j_q + CW'(1);
		end
	end

	assign raddr_a = i_n[AW-1:0];
	assign raddr_b = j_n[AW-1:0];

	// a hit is held back one step so the final word can carry last
	assign push.vld     = step && (done || (hit && pend_v_q));
	assign push.present = done ? pend_v_q : 1'b1;
	assign push.last    = done;
	assign push_id      = (done && !pend_v_q) ? '0 : pend_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_AND;
			i_q      <= '0;
			j_q      <= '0;
			pend_v_q <= 1'b0;
		end else begin
			i_q <= i_n;
			j_q <= j_n;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_MERGE;
						op_q     <= op;
						pend_v_q <= 1'b0;
					end
				end
				ST_MERGE: begin
					if (step && done) begin
						state_q <= ST_IDLE;
					end else if (step && hit) begin
						pend_v_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			pend_id_q <= hit_id;
		end
	end

endmodule

[rtl/core/posting_list_merge_engine.sv]
// Posting list merge engine. Input words with action append-A / append-B write one document id
// into list A or list B (one word per cycle, ascending order expected); clear empties both lists
// and the sticky overflow flag; run merges the lists with op AND, OR or NOT (B minus A) and
// streams the result ids in ascending order, last set on the final word, or one word with
// present low if nothing matches. Appends to a full list are dropped and set overflowed, which
// every result word of later runs carries until a clear. A run holds the input off for at most
// count_a + count_b + 1 merge steps (one merge step per cycle while the output register has room,
// bound by the single read port of each list RAM); a new result word enters as the held one is taken.
module posting_list_merge_engine import plme_pkg::*; #(
	parameter int LIST_DEPTH = 32,
	parameter int ID_WIDTH   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	plme_in_if.sink   in_ch,
	plme_out_if.source out_ch
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic [CW-1:0]          cnt_a_q, cnt_b_q;
	logic                   ovf_q;
	logic                   in_fire, start, busy, slot_free;
	logic                   full_a, full_b, we_a, we_b;
	logic [ID_WIDTH+15:0]   id_ext;
	logic [ID_WIDTH-1:0]    id_in, rd_a, rd_b, push_id;
	logic [AW-1:0]          raddr_a, raddr_b;
	plme_push_t             push;

	logic                   out_v_q;
	logic [ID_WIDTH-1:0]    res_id_q;
	logic                   res_present_q, res_last_q, res_ovf_q;
	logic [ID_WIDTH+15:0]   res_ext;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !busy;
	assign start     = in_fire && (in_ch.action == ACT_RUN);
	assign id_ext    = {{ID_WIDTH{1'b0}}, in_ch.doc_id};
	assign id_in     = id_ext[ID_WIDTH-1:0];
	assign full_a    = cnt_a_q >= CW'(LIST_DEPTH);
	assign full_b    = cnt_b_q >= CW'(LIST_DEPTH);
	assign we_a      = in_fire && (in_ch.action == ACT_APPEND_A) && !full_a;
	assign we_b      = in_fire && (in_ch.action == ACT_APPEND_B) && !full_b;
	assign slot_free = !out_v_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_fire) begin
			unique case (in_ch.action)
				ACT_CLEAR: begin
					cnt_a_q <= '0;
					cnt_b_q <= '0;
					ovf_q   <= 1'b0;
				end
				ACT_APPEND_A: begin
					if (full_a) ovf_q <= 1'b1;
					else cnt_a_q <= cnt_a_q + CW'(1);
				end
				ACT_APPEND_B: begin
					if (full_b) ovf_q <= 1'b1;
					else cnt_b_q <= cnt_b_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	plme_ram #(.WIDTH(ID_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (id_in),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	plme_ram #(.WIDTH(ID_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (id_in),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	plme_merge #(
		.ID_WIDTH   (ID_WIDTH),
		.AW         (AW),
		.CW         (CW)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (in_ch.op),
		.cnt_a     (cnt_a_q),
		.cnt_b     (cnt_b_q),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.slot_free (slot_free),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.busy      (busy),
		.push      (push),
		.push_id   (push_id)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push.vld) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			res_id_q      <= push_id;
			res_present_q <= push.present;
			res_last_q    <= push.last;
			res_ovf_q     <= ovf_q;
		end
	end

	assign res_ext           = {16'd0, res_id_q};
	assign out_ch.valid      = out_v_q;
	assign out_ch.result_id  = res_ext[15:0];
	assign out_ch.present    = res_present_q;
	assign out_ch.last       = res_last_q;
	assign out_ch.overflowed = res_ovf_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CW'(LIST_DEPTH)) && (cnt_b_q <= CW'(LIST_DEPTH)))
		else $error("list count beyond depth");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.present) |-> out_ch.last)
		else $error("absent word not marked last");

	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && (in_ch.action == ACT_RUN)) |=> !in_ch.ready)
		else $error("input taken during run");

	a_no_push_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> ($stable(out_ch.result_id) && out_ch.valid))
		else $error("output word overwritten while stalled");
`endif

endmodule
